FILE: sv/utc_timestamp_to_epoch_nanoseconds_defines.svh
// Assertion macros shared by the timestamp converter.
`ifndef UTC_TIMESTAMP_TO_EPOCH_NANOSECONDS_DEFINES_SVH
`define UTC_TIMESTAMP_TO_EPOCH_NANOSECONDS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UTCTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UTCTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/utcts_pkg.sv
// Types, constants and tables of the timestamp converter.
package utcts_pkg;

  localparam int MAX_LENGTH_DEF = 30;

  localparam int POS_W    = 6;
  localparam int YEAR_W   = 14;
  localparam int FIELD_W  = 7;
  localparam int FRAC_W   = 30;
  localparam int OP_A_W   = 33;
  localparam int OP_B_W   = 32;
  localparam int PROD_W   = OP_A_W + OP_A_W;
  localparam int ACC_W    = 72;
  localparam int SECS_W   = 40;
  localparam int QUOT_W   = 8;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_Z     = 8'h5A;

  localparam logic [OP_B_W-1:0] K_DIV100      = 32'd5243;
  localparam int                DIV100_SHIFT  = 19;
  localparam logic [OP_B_W-1:0] K_HUNDRED     = 32'd100;
  localparam logic [OP_B_W-1:0] SEC_PER_YEAR  = 32'd31536000;
  localparam logic [OP_B_W-1:0] SEC_PER_DAY   = 32'd86400;
  localparam logic [OP_B_W-1:0] SEC_PER_HOUR  = 32'd3600;
  localparam logic [OP_B_W-1:0] SEC_PER_MIN   = 32'd60;
  localparam logic [OP_B_W-1:0] K_ONE         = 32'd1;
  localparam logic [OP_B_W-1:0] NS_PER_S      = 32'd1000000000;
  localparam logic signed [OP_A_W-1:0] EPOCH_OFS = -33'sd719469;

  typedef logic [3:0] step_t;
  localparam step_t STEP_DIV   = 4'd0;
  localparam step_t STEP_REM   = 4'd1;
  localparam step_t STEP_YEAR  = 4'd2;
  localparam step_t STEP_LEAP4 = 4'd3;
  localparam step_t STEP_CENT  = 4'd4;
  localparam step_t STEP_QUAD  = 4'd5;
  localparam step_t STEP_DOY   = 4'd6;
  localparam step_t STEP_DAY   = 4'd7;
  localparam step_t STEP_EPOCH = 4'd8;
  localparam step_t STEP_HOUR  = 4'd9;
  localparam step_t STEP_MIN   = 4'd10;
  localparam step_t STEP_SEC   = 4'd11;
  localparam step_t STEP_FRAC  = 4'd12;
  localparam step_t STEP_NS_LO = 4'd13;
  localparam step_t STEP_NS_HI = 4'd14;
  localparam step_t STEP_LAST  = STEP_NS_HI;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic               status;
    logic signed [63:0] timestamp_ns;
  } out_word_t;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic [FRAC_W-1:0]  fraction;
    logic               format_bad;
  } scan_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
    logic hi_shift;
  } mac_ctrl_t;

  function automatic logic [8:0] day_of_year_base(logic [FIELD_W-1:0] month);
    logic [8:0] r;
    unique case (month)
      7'd1:    r = 9'd306;
      7'd2:    r = 9'd337;
      7'd3:    r = 9'd0;
      7'd4:    r = 9'd31;
      7'd5:    r = 9'd61;
      7'd6:    r = 9'd92;
      7'd7:    r = 9'd122;
      7'd8:    r = 9'd153;
      7'd9:    r = 9'd184;
      7'd10:   r = 9'd214;
      7'd11:   r = 9'd245;
      7'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(logic [FIELD_W-1:0] month, logic leap);
    logic [4:0] r;
    unique case (month)
      7'd2:                          r = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:       r = 5'd30;
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8,
      7'd10, 7'd12:                  r = 5'd31;
      default:                       r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [OP_B_W-1:0] frac_scale(logic [POS_W-1:0] pos);
    logic [OP_B_W-1:0] r;
    unique case (pos)
      6'd21:   r = 32'd100000000;
      6'd22:   r = 32'd10000000;
      6'd23:   r = 32'd1000000;
      6'd24:   r = 32'd100000;
      6'd25:   r = 32'd10000;
      6'd26:   r = 32'd1000;
      6'd27:   r = 32'd100;
      6'd28:   r = 32'd10;
      6'd29:   r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/utcts_scan.sv
// Character scanner: field positions, separator checks and digit accumulators.
module utcts_scan #(
  parameter int MAX_LENGTH = utcts_pkg::MAX_LENGTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [7:0]       character,
  input  logic             clear,
  output utcts_pkg::scan_t scan
);
  import utcts_pkg::*;

  scan_t scan_r;
  scan_t scan_nxt;
  logic       is_digit;
  logic [3:0] digit;

  function automatic logic [FRAC_W-1:0] acc10(logic [FRAC_W-1:0] a, logic [3:0] d);
    return FRAC_W'(a * FRAC_W'(10) + FRAC_W'(d));
  endfunction

  assign is_digit = (character >= CH_0) && (character <= CH_9);
  assign digit    = 4'(character - CH_0);

  always_comb begin
    scan_nxt = scan_r;
    if (clear) begin
      scan_nxt = '0;
    end else if (advance) begin
      priority if (scan_r.position <= 6'd3) begin
        if (is_digit) scan_nxt.year = YEAR_W'(acc10(FRAC_W'(scan_r.year), digit));
        else scan_nxt.format_bad = 1'b1;
      end else if (scan_r.position == 6'd4 || scan_r.position == 6'd7) begin
        if (character != CH_DASH) scan_nxt.format_bad = 1'b1;
      end else if (scan_r.position == 6'd5 || scan_r.position == 6'd6) begin
        if (is_digit) scan_nxt.month = FIELD_W'(acc10(FRAC_W'(scan_r.month), digit));
        else scan_nxt.format_bad = 1'b1;
      end else if (scan_r.position == 6'd8 || scan_r.position == 6'd9) begin
        if (is_digit) scan_nxt.day = FIELD_W'(acc10(FRAC_W'(scan_r.day), digit));
        else scan_nxt.format_bad = 1'b1;
      end else if (scan_r.position == 6'd10) begin
        if (character != CH_T) scan_nxt.format_bad = 1'b1;
      end else if (scan_r.position == 6'd11 || scan_r.position == 6'd12) begin
        if (is_digit) scan_nxt.hour = FIELD_W'(acc10(FRAC_W'(scan_r.hour), digit));
        else scan_nxt.format_bad = 1'b1;
      end else if (scan_r.position == 6'd13 || scan_r.position == 6'd16) begin
        if (character != CH_COLON) scan_nxt.format_bad = 1'b1;
      end else if (scan_r.position == 6'd14 || scan_r.position == 6'd15) begin
        if (is_digit) scan_nxt.minute = FIELD_W'(acc10(FRAC_W'(scan_r.minute), digit));
        else scan_nxt.format_bad = 1'b1;
      end else if (scan_r.position == 6'd17 || scan_r.position == 6'd18) begin
        if (is_digit) scan_nxt.second = FIELD_W'(acc10(FRAC_W'(scan_r.second), digit));
        else scan_nxt.format_bad = 1'b1;
      end else if (scan_r.position == 6'd19) begin
        if (character != CH_DOT) scan_nxt.format_bad = 1'b1;
      end else if (scan_r.position >= POS_W'(MAX_LENGTH - 1) || scan_r.position > 6'd28)
      begin
        scan_nxt.format_bad = 1'b1;
      end else begin
        if (is_digit) scan_nxt.fraction = acc10(scan_r.fraction, digit);
        else scan_nxt.format_bad = 1'b1;
      end
      if (scan_r.position != POS_MAX) scan_nxt.position = scan_r.position + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  assign scan = scan_r;

endmodule

FILE: sv/utcts_mac.sv
// Shared multiply-accumulate unit: registered 33x33 product into a wide accumulator.
module utcts_mac (
  input  logic                                     clk,
  input  utcts_pkg::mac_ctrl_t                     ctrl,
  input  logic signed [utcts_pkg::OP_A_W-1:0]      op_a,
  input  logic        [utcts_pkg::OP_B_W-1:0]      op_b,
  output logic signed [utcts_pkg::PROD_W-1:0]      prod,
  output logic signed [utcts_pkg::ACC_W-1:0]       acc
);
  import utcts_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [OP_A_W-1:0] op_b_s;
  logic signed [ACC_W-1:0]  addend;

  assign op_b_s = $signed({1'b0, op_b});
  assign addend = ctrl.hi_shift ? {prod_r[ACC_W-33:0], 32'd0}
                                : {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) prod_r <= op_a * op_b_s;
    if (ctrl.acc_clr) acc_r <= '0;
    else if (ctrl.acc_en) acc_r <= acc_r + addend;
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

FILE: sv/utc_timestamp_to_epoch_nanoseconds.sv
// Top level of the UTC timestamp to Unix nanoseconds converter.
// Takes YYYY-MM-DDTHH:MM:SS[.f{1..9}]Z one character per word, with last set on
// the final 'Z'. A character that is not last is taken while the converter is
// idle and gives no result. The last character starts a 15-step sequence on one
// shared 33x33 multiply-accumulate unit, each step a multiply state and then an
// accumulate state; the input is not ready until the sequence has finished and
// its result has gone into the output register, which waits while a held result
// is not yet taken. A bad format, a date that does not exist, an out of range
// time or a value that does not fit 64 signed bits gives status 1 with timestamp
// 0. The result waits in an output register, so the next string may start while
// it is still held.
`include "utc_timestamp_to_epoch_nanoseconds_defines.svh"

module utc_timestamp_to_epoch_nanoseconds #(
  parameter int MAX_LENGTH = utcts_pkg::MAX_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  utcts_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utcts_pkg::out_word_t out_word
);
  import utcts_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ACC  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t    state_r, state_nxt;
  step_t     step_r, step_nxt;
  logic [QUOT_W-1:0] q_r;
  logic      rem0_r;
  logic      fmt_ok_r;
  logic [SECS_W-1:0] secs_r;
  logic      out_valid_r;
  out_word_t out_word_r;

  scan_t     scan;
  mac_ctrl_t mac_ctrl;
  logic signed [OP_A_W-1:0] op_a;
  logic        [OP_B_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic in_fire, done_fire, out_free, fmt_ok;
  logic early, leap, date_ok, time_ok, fits, ok;
  logic signed [YEAR_W:0]   yy;
  logic signed [QUOT_W:0]   cent;
  logic [4:0] mdays;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign done_fire = (state_r == ST_DONE) && out_free;

  utcts_scan #(.MAX_LENGTH(MAX_LENGTH)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (in_fire && !in_word.last),
    .character (in_word.character),
    .clear     (done_fire),
    .scan      (scan)
  );

  utcts_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod),
    .acc  (acc)
  );

  assign fmt_ok = !scan.format_bad && (in_word.character == CH_Z) &&
                  (scan.position != POS_MAX) &&
                  ((scan.position == 6'd19) ||
                   (scan.position >= 6'd21 && scan.position <= POS_W'(MAX_LENGTH - 1)));

  assign early = (scan.month <= 7'd2);
  assign yy    = $signed({1'b0, scan.year}) - $signed({{YEAR_W{1'b0}}, early});
  assign cent  = $signed({1'b0, q_r}) - $signed({{QUOT_W{1'b0}}, early && rem0_r});

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_r)
      STEP_DIV:   begin op_a = {19'd0, scan.year};  op_b = K_DIV100;     end
      STEP_REM:   begin op_a = {25'd0, q_r};        op_b = K_HUNDRED;    end
      STEP_YEAR:  begin op_a = {{18{yy[YEAR_W]}}, yy}; op_b = SEC_PER_YEAR; end
      STEP_LEAP4: begin
        op_a = {{18{yy[YEAR_W]}}, yy} >>> 2;
        op_b = SEC_PER_DAY;
      end
      STEP_CENT:  begin
        op_a = 33'sd0 - {{24{cent[QUOT_W]}}, cent};
        op_b = SEC_PER_DAY;
      end
      STEP_QUAD:  begin
        op_a = {{24{cent[QUOT_W]}}, cent} >>> 2;
        op_b = SEC_PER_DAY;
      end
      STEP_DOY:   begin op_a = {24'd0, day_of_year_base(scan.month)}; op_b = SEC_PER_DAY; end
      STEP_DAY:   begin op_a = {26'd0, scan.day};    op_b = SEC_PER_DAY;  end
      STEP_EPOCH: begin op_a = EPOCH_OFS;            op_b = SEC_PER_DAY;  end
      STEP_HOUR:  begin op_a = {26'd0, scan.hour};   op_b = SEC_PER_HOUR; end
      STEP_MIN:   begin op_a = {26'd0, scan.minute}; op_b = SEC_PER_MIN;  end
      STEP_SEC:   begin op_a = {26'd0, scan.second}; op_b = K_ONE;        end
      STEP_FRAC:  begin
        op_a = {3'd0, scan.fraction};
        op_b = frac_scale(scan.position);
      end
      STEP_NS_LO: begin op_a = {1'b0, secs_r[31:0]}; op_b = NS_PER_S; end
      STEP_NS_HI: begin
        op_a = {{25{secs_r[SECS_W-1]}}, secs_r[SECS_W-1:32]};
        op_b = NS_PER_S;
      end
      default:    begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    mac_ctrl.mul_en   = (state_r == ST_MUL);
    mac_ctrl.acc_clr  = (state_r == ST_MUL) &&
                        (step_r == STEP_YEAR || step_r == STEP_FRAC);
    mac_ctrl.acc_en   = (state_r == ST_ACC) && (step_r >= STEP_YEAR);
    mac_ctrl.hi_shift = (step_r == STEP_NS_HI);
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_word.last) begin
          state_nxt = ST_MUL;
          step_nxt  = STEP_DIV;
        end
      end
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
          step_nxt  = step_r + 4'd1;
        end
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign leap    = ((scan.year[1:0] == 2'd0) && !rem0_r) || (rem0_r && (q_r[1:0] == 2'd0));
  assign mdays   = month_days(scan.month, leap);
  assign date_ok = (scan.year != '0) && (scan.month >= 7'd1) && (scan.month <= 7'd12) &&
                   (scan.day >= 7'd1) && (scan.day <= {2'd0, mdays});
  assign time_ok = (scan.hour <= 7'd23) && (scan.minute <= 7'd59) && (scan.second <= 7'd59);
  assign fits    = (&acc[ACC_W-1:63]) || !(|acc[ACC_W-1:63]);
  assign ok      = fmt_ok_r && date_ok && time_ok && fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_DIV;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (done_fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_word.last) fmt_ok_r <= fmt_ok;
    if (state_r == ST_ACC && step_r == STEP_DIV) q_r <= prod[DIV100_SHIFT +: QUOT_W];
    if (state_r == ST_ACC && step_r == STEP_REM) rem0_r <= (prod[YEAR_W-1:0] == scan.year);
    if (state_r == ST_MUL && step_r == STEP_FRAC) secs_r <= acc[SECS_W-1:0];
    if (done_fire) begin
      out_word_r.status       <= !ok;
      out_word_r.timestamp_ns <= ok ? acc[63:0] : 64'sd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `UTCTS_ASSERT_NXT(a_done_loads, state_r == ST_DONE && !out_valid_r, out_valid_r, "no load")
  `UTCTS_ASSERT_IMP(a_bad_zero, out_valid_r && out_word_r.status, out_word_r.timestamp_ns == '0, "bad ts")
  `UTCTS_ASSERT_NXT(a_last_starts, in_fire && in_word.last, state_r == ST_MUL, "no start")
  `UTCTS_ASSERT_IMP(a_acc_after_mul, state_r == ST_ACC, $past(state_r) == ST_MUL, "acc without mul")

endmodule
